>>> hw/rtl/ray_mesh_closest_hit_unit_defines.svh
// Assertion macros shared by the closest-hit unit RTL.
`ifndef RAY_MESH_CLOSEST_HIT_UNIT_DEFINES_SVH
`define RAY_MESH_CLOSEST_HIT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMCH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rmch_pkg.sv
// Shared types, constants and the product program of the closest-hit unit.
`timescale 1ns / 1ps

package rmch_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NUM_W           = 32;
   localparam int PROG_LEN        = 24;
   localparam int STEP_W          = 5;
   localparam int CSR_IDX_W       = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_ORIGIN_Z,
      CSR_DIR_X,
      CSR_DIR_Y,
      CSR_DIR_Z,
      CSR_THRESHOLD
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ISSUE,
      ST_MUL,
      ST_ACC,
      ST_CHECK,
      ST_DIVGO,
      ST_DIVW,
      ST_UPDATE,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {CHK_DET, CHK_U, CHK_V, CHK_T} check_type;

   typedef enum logic [1:0] {DIV_T, DIV_U, DIV_V} div_sel_type;

   // wide multiplicand sources
   typedef enum logic [3:0] {
      WID_E1_X, WID_E1_Y, WID_E1_Z,
      WID_E2_X, WID_E2_Y, WID_E2_Z,
      WID_P_X,  WID_P_Y,  WID_P_Z,
      WID_Q_X,  WID_Q_Y,  WID_Q_Z
   } wide_sel_type;

   // narrow multiplier sources
   typedef enum logic [3:0] {
      NAR_E1_X,  NAR_E1_Y,  NAR_E1_Z,
      NAR_E2_X,  NAR_E2_Y,  NAR_E2_Z,
      NAR_TV_X,  NAR_TV_Y,  NAR_TV_Z,
      NAR_DIR_X, NAR_DIR_Y, NAR_DIR_Z
   } narrow_sel_type;

   // where a finished sum of products goes
   typedef enum logic [3:0] {
      DST_NONE,
      DST_P_X, DST_P_Y, DST_P_Z,
      DST_Q_X, DST_Q_Y, DST_Q_Z,
      DST_DET, DST_UN, DST_VN, DST_TN
   } dst_sel_type;

   typedef struct packed {
      wide_sel_type   a_sel;
      narrow_sel_type b_sel;
      logic           neg;
      dst_sel_type    dst;
   } prog_step_type;

   function automatic prog_step_type mk_step(input wide_sel_type a, input narrow_sel_type b,
                                             input logic neg, input dst_sel_type dst);
      prog_step_type s;
      s.a_sel = a;
      s.b_sel = b;
      s.neg   = neg;
      s.dst   = dst;
      return s;
   endfunction

   // p = dir x e2, det = e1.p, un = tv.p, q = tv x e1, vn = dir.q, tn = e2.q
   function automatic prog_step_type prog_entry(input logic [STEP_W-1:0] idx);
      prog_step_type s;
      unique case (idx)
         5'd0:    s = mk_step(WID_E2_Z, NAR_DIR_Y, 1'b0, DST_NONE);
         5'd1:    s = mk_step(WID_E2_Y, NAR_DIR_Z, 1'b1, DST_P_X);
         5'd2:    s = mk_step(WID_E2_X, NAR_DIR_Z, 1'b0, DST_NONE);
         5'd3:    s = mk_step(WID_E2_Z, NAR_DIR_X, 1'b1, DST_P_Y);
         5'd4:    s = mk_step(WID_E2_Y, NAR_DIR_X, 1'b0, DST_NONE);
         5'd5:    s = mk_step(WID_E2_X, NAR_DIR_Y, 1'b1, DST_P_Z);
         5'd6:    s = mk_step(WID_P_X,  NAR_E1_X,  1'b0, DST_NONE);
         5'd7:    s = mk_step(WID_P_Y,  NAR_E1_Y,  1'b0, DST_NONE);
         5'd8:    s = mk_step(WID_P_Z,  NAR_E1_Z,  1'b0, DST_DET);
         5'd9:    s = mk_step(WID_P_X,  NAR_TV_X,  1'b0, DST_NONE);
         5'd10:   s = mk_step(WID_P_Y,  NAR_TV_Y,  1'b0, DST_NONE);
         5'd11:   s = mk_step(WID_P_Z,  NAR_TV_Z,  1'b0, DST_UN);
         5'd12:   s = mk_step(WID_E1_Z, NAR_TV_Y,  1'b0, DST_NONE);
         5'd13:   s = mk_step(WID_E1_Y, NAR_TV_Z,  1'b1, DST_Q_X);
         5'd14:   s = mk_step(WID_E1_X, NAR_TV_Z,  1'b0, DST_NONE);
         5'd15:   s = mk_step(WID_E1_Z, NAR_TV_X,  1'b1, DST_Q_Y);
         5'd16:   s = mk_step(WID_E1_Y, NAR_TV_X,  1'b0, DST_NONE);
         5'd17:   s = mk_step(WID_E1_X, NAR_TV_Y,  1'b1, DST_Q_Z);
         5'd18:   s = mk_step(WID_Q_X,  NAR_DIR_X, 1'b0, DST_NONE);
         5'd19:   s = mk_step(WID_Q_Y,  NAR_DIR_Y, 1'b0, DST_NONE);
         5'd20:   s = mk_step(WID_Q_Z,  NAR_DIR_Z, 1'b0, DST_VN);
         5'd21:   s = mk_step(WID_Q_X,  NAR_E2_X,  1'b0, DST_NONE);
         5'd22:   s = mk_step(WID_Q_Y,  NAR_E2_Y,  1'b0, DST_NONE);
         5'd23:   s = mk_step(WID_Q_Z,  NAR_E2_Z,  1'b0, DST_TN);
         default: s = mk_step(WID_E1_X, NAR_E1_X,  1'b0, DST_NONE);
      endcase
      return s;
   endfunction

endpackage

>>> hw/rtl/rmch_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module rmch_mul
   import rmch_pkg::*;
#(
   parameter int A_W = 3 * COORD_WIDTH_DEF + 8,
   parameter int B_W = COORD_WIDTH_DEF + 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           done,
   output logic [A_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [A_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [A_W-1:0]   prod_ff, prod_in;
   logic [A_W-1:0]   term;

   // shift-add step; the sign bit of b weighs negative
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      term    = '0;
      if (b_ff[cnt_ff]) begin
         term = (cnt_ff == CNT_W'(B_W - 1)) ? (~a_ff + 1'b1) : a_ff;
      end
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(B_W - 1);
         a_in    = a;
         b_in    = b;
         prod_in = '0;
      end else if (busy_ff) begin
         prod_in = {prod_ff[A_W-2:0], 1'b0} + term;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operands and partial product
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

>>> hw/rtl/rmch_div.sv
// Restoring divider: floor((num << F) / den), one quotient bit per cycle, saturating.
`timescale 1ns / 1ps

module rmch_div
   import rmch_pkg::*;
#(
   parameter int N_W = 3 * COORD_WIDTH_DEF + 8,
   parameter int Q_W = COORD_WIDTH_DEF,
   parameter int F   = FRAC_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] num,
   input  logic [N_W-1:0] den,
   output logic           done,
   output logic [Q_W-1:0] quotient
);

   localparam int DVD_W = N_W + F;
   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [N_W-1:0]   den_ff, den_in;
   logic [N_W-1:0]   rem_ff, rem_in;
   logic [Q_W-2:0]   quo_ff, quo_in;
   logic             ovf_ff, ovf_in;
   logic [N_W:0]     trial;
   logic [N_W:0]     diff;
   logic             ge;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   // one long-division step; any bit leaving the quotient window saturates
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W - 1);
         dvd_in  = {num, {F{1'b0}}};
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[N_W-1:0] : trial[N_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[Q_W-3:0], ge};
         ovf_in = ovf_ff | quo_ff[Q_W-2];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = ovf_ff ? {1'b0, {(Q_W-1){1'b1}}} : {1'b0, quo_ff};

endmodule

>>> hw/rtl/ray_mesh_closest_hit_unit.sv
// Closest front-facing ray/triangle hit over a stream of mesh vertices.
`timescale 1ns / 1ps
// Usage:
//  csr_*: write ray origin, direction and determinant threshold (index 0..6)
//    while the unit is idle; csr_ready is always high.
//  req_*: one vertex per word. Every third vertex closes a triangle, which
//    is tested against the ray; the word marked last closes the mesh.
//  rsp_*: one word per mesh: hit flag, t, u, v and the triangle's vertex
//    numbers, all zero when nothing was hit.
// Sequence: the first two vertices of a triangle are only held. The third runs
//  24 products through one bit-serial multiplier, then up to 4 checks and, if
//  all pass, 3 divides on one serial divider; req_ready stays low until the
//  triangle is done. The multiplier and divider set the rate.
// The result sits in an output register; if the receiver stalls, the unit
//  keeps taking vertices and holds only when a new mesh result is ready.
// Reset: configuration returns to origin 0, direction (0, 0, 1.0),
//  threshold 1; the mesh state is cleared.
`include "ray_mesh_closest_hit_unit_defines.svh"

module ray_mesh_closest_hit_unit
   import rmch_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [COORD_WIDTH-1:0] req_coord_z,
   input  logic [NUM_W-1:0]              req_vertex_number,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_t,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_u,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_v,
   output logic [NUM_W-1:0]              rsp_hit_vertex_a,
   output logic [NUM_W-1:0]              rsp_hit_vertex_b,
   output logic [NUM_W-1:0]              rsp_hit_vertex_c
);

   localparam int CW    = COORD_WIDTH;
   localparam int NW_W  = CW + 1;
   localparam int PQ_W  = 2 * CW + 3;
   localparam int ACC_W = 3 * CW + 8;
   localparam logic [CW-1:0] DIR_Z_RST = CW'(1) << FRAC_BITS;

   function automatic logic [NW_W-1:0] ext_c(input logic [CW-1:0] x);
      return {x[CW-1], x};
   endfunction

   function automatic logic [ACC_W-1:0] ext_nw(input logic [NW_W-1:0] x);
      return {{(ACC_W-NW_W){x[NW_W-1]}}, x};
   endfunction

   function automatic logic [ACC_W-1:0] ext_pq(input logic [PQ_W-1:0] x);
      return {{(ACC_W-PQ_W){x[PQ_W-1]}}, x};
   endfunction

   // configuration
   logic [CW-1:0]   org_ff [3];
   logic [CW-1:0]   org_in [3];
   logic [CW-1:0]   dir_ff [3];
   logic [CW-1:0]   dir_in [3];
   logic [CW-2:0]   thr_ff, thr_in;

   // mesh state
   state_type       state_ff, state_in;
   logic [1:0]      phase_ff, phase_in;
   logic [CW-1:0]   held_ff [6];
   logic [CW-1:0]   held_in [6];
   logic [NUM_W-1:0] hnum_ff [2];
   logic [NUM_W-1:0] hnum_in [2];
   logic [CW-1:0]   cur_ff [3];
   logic [CW-1:0]   cur_in [3];
   logic [NUM_W-1:0] cnum_ff, cnum_in;
   logic            clast_ff, clast_in;

   // triangle datapath
   logic [NW_W-1:0] e1_ff [3];
   logic [NW_W-1:0] e1_in [3];
   logic [NW_W-1:0] e2_ff [3];
   logic [NW_W-1:0] e2_in [3];
   logic [NW_W-1:0] tv_ff [3];
   logic [NW_W-1:0] tv_in [3];
   logic [PQ_W-1:0] p_ff [3];
   logic [PQ_W-1:0] p_in [3];
   logic [PQ_W-1:0] q_ff [3];
   logic [PQ_W-1:0] q_in [3];
   logic [ACC_W-1:0] det_ff, det_in, un_ff, un_in, vn_ff, vn_in, tn_ff, tn_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [STEP_W-1:0] step_ff, step_in;
   check_type       chk_ff, chk_in;
   div_sel_type     dsel_ff, dsel_in;
   logic [CW-1:0]   t_ff, t_in, u_ff, u_in, v_ff, v_in;

   // best hit
   logic            best_found_ff, best_found_in;
   logic [CW-1:0]   best_t_ff, best_t_in, best_u_ff, best_u_in, best_v_ff, best_v_in;
   logic [NUM_W-1:0] bvert_ff [3];
   logic [NUM_W-1:0] bvert_in [3];

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_hit_ff, rsp_hit_in;
   logic [CW-1:0]   rsp_t_ff, rsp_t_in, rsp_u_ff, rsp_u_in, rsp_v_ff, rsp_v_in;
   logic [NUM_W-1:0] rsp_vert_ff [3];
   logic [NUM_W-1:0] rsp_vert_in [3];

   // shared units
   prog_step_type   prog;
   logic            mul_start, mul_done;
   logic [ACC_W-1:0] mul_a, mul_prod, mul_term, acc_sum;
   logic [NW_W-1:0] mul_b;
   logic            div_start, div_done;
   logic [ACC_W-1:0] div_num;
   logic [CW-1:0]   div_quo;

   logic            req_go, emit_go, chk_pass, mesh_idle;
   logic [ACC_W-1:0] det_hi, thr_ext, uv_sum;

   assign prog      = prog_entry(step_ff);
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_go    = req_valid && req_ready;
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign mesh_idle = rsp_valid_ff && !best_found_ff && (phase_ff == 2'd0);

   // wide operand select
   always_comb begin
      unique case (prog.a_sel)
         WID_E1_X: mul_a = ext_nw(e1_ff[0]);
         WID_E1_Y: mul_a = ext_nw(e1_ff[1]);
         WID_E1_Z: mul_a = ext_nw(e1_ff[2]);
         WID_E2_X: mul_a = ext_nw(e2_ff[0]);
         WID_E2_Y: mul_a = ext_nw(e2_ff[1]);
         WID_E2_Z: mul_a = ext_nw(e2_ff[2]);
         WID_P_X:  mul_a = ext_pq(p_ff[0]);
         WID_P_Y:  mul_a = ext_pq(p_ff[1]);
         WID_P_Z:  mul_a = ext_pq(p_ff[2]);
         WID_Q_X:  mul_a = ext_pq(q_ff[0]);
         WID_Q_Y:  mul_a = ext_pq(q_ff[1]);
         WID_Q_Z:  mul_a = ext_pq(q_ff[2]);
         default:  mul_a = '0;
      endcase
   end

   // narrow operand select
   always_comb begin
      unique case (prog.b_sel)
         NAR_E1_X:  mul_b = e1_ff[0];
         NAR_E1_Y:  mul_b = e1_ff[1];
         NAR_E1_Z:  mul_b = e1_ff[2];
         NAR_E2_X:  mul_b = e2_ff[0];
         NAR_E2_Y:  mul_b = e2_ff[1];
         NAR_E2_Z:  mul_b = e2_ff[2];
         NAR_TV_X:  mul_b = tv_ff[0];
         NAR_TV_Y:  mul_b = tv_ff[1];
         NAR_TV_Z:  mul_b = tv_ff[2];
         NAR_DIR_X: mul_b = ext_c(dir_ff[0]);
         NAR_DIR_Y: mul_b = ext_c(dir_ff[1]);
         NAR_DIR_Z: mul_b = ext_c(dir_ff[2]);
         default:   mul_b = '0;
      endcase
   end

   // dividend select
   always_comb begin
      unique case (dsel_ff)
         DIV_T:   div_num = tn_ff;
         DIV_U:   div_num = un_ff;
         DIV_V:   div_num = vn_ff;
         default: div_num = tn_ff;
      endcase
   end

   assign mul_term = prog.neg ? (~mul_prod + 1'b1) : mul_prod;
   assign acc_sum  = acc_ff + mul_term;

   // hit tests, one per check cycle
   assign det_hi  = det_ff >> (2 * FRAC_BITS);
   assign thr_ext = {{(ACC_W-CW+1){1'b0}}, thr_ff};
   assign uv_sum  = un_ff + vn_ff;

   always_comb begin
      unique case (chk_ff)
         CHK_DET: chk_pass = ($signed(det_ff) > 0) && (det_hi >= thr_ext);
         CHK_U:   chk_pass = !un_ff[ACC_W-1] && !($signed(det_ff) < $signed(un_ff));
         CHK_V:   chk_pass = !vn_ff[ACC_W-1] && !($signed(det_ff) < $signed(uv_sum));
         CHK_T:   chk_pass = ($signed(tn_ff) > 0);
         default: chk_pass = 1'b0;
      endcase
   end

   rmch_mul #(
      .A_W (ACC_W),
      .B_W (NW_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   rmch_div #(
      .N_W (ACC_W),
      .Q_W (CW),
      .F   (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (det_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               state_in = (phase_ff == 2'd2) ? ST_SETUP : ST_FINISH;
            end
         end
         ST_SETUP:  state_in = ST_ISSUE;
         ST_ISSUE:  state_in = ST_MUL;
         ST_MUL: begin
            if (mul_done) state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = (step_ff == STEP_W'(PROG_LEN - 1)) ? ST_CHECK : ST_ISSUE;
         end
         ST_CHECK: begin
            if (!chk_pass) state_in = ST_FINISH;
            else if (chk_ff == CHK_T) state_in = ST_DIVGO;
         end
         ST_DIVGO:  state_in = ST_DIVW;
         ST_DIVW: begin
            if (div_done) state_in = (dsel_ff == DIV_V) ? ST_UPDATE : ST_DIVGO;
         end
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: state_in = clast_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (emit_go) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and register updates
   always_comb begin
      org_in        = org_ff;
      dir_in        = dir_ff;
      thr_in        = thr_ff;
      phase_in      = phase_ff;
      held_in       = held_ff;
      hnum_in       = hnum_ff;
      cur_in        = cur_ff;
      cnum_in       = cnum_ff;
      clast_in      = clast_ff;
      e1_in         = e1_ff;
      e2_in         = e2_ff;
      tv_in         = tv_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      det_in        = det_ff;
      un_in         = un_ff;
      vn_in         = vn_ff;
      tn_in         = tn_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      chk_in        = chk_ff;
      dsel_in       = dsel_ff;
      t_in          = t_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      best_found_in = best_found_ff;
      best_t_in     = best_t_ff;
      best_u_in     = best_u_ff;
      best_v_in     = best_v_ff;
      bvert_in      = bvert_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_t_in      = rsp_t_ff;
      rsp_u_in      = rsp_u_ff;
      rsp_v_in      = rsp_v_ff;
      rsp_vert_in   = rsp_vert_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mul_start     = 1'b0;
      div_start     = 1'b0;

      // register writes; indexes past the list are dropped
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ORIGIN_X:  org_in[0] = csr_data;
            CSR_ORIGIN_Y:  org_in[1] = csr_data;
            CSR_ORIGIN_Z:  org_in[2] = csr_data;
            CSR_DIR_X:     dir_in[0] = csr_data;
            CSR_DIR_Y:     dir_in[1] = csr_data;
            CSR_DIR_Z:     dir_in[2] = csr_data;
            CSR_THRESHOLD: thr_in    = csr_data[CW-2:0];
            default:       ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // hold the first two corners, launch on the third
            if (req_go) begin
               cur_in[0] = req_coord_x;
               cur_in[1] = req_coord_y;
               cur_in[2] = req_coord_z;
               cnum_in   = req_vertex_number;
               clast_in  = req_last_vertex;
               if (phase_ff == 2'd2) begin
                  phase_in = 2'd0;
               end else if (phase_ff[0]) begin
                  held_in[3] = req_coord_x;
                  held_in[4] = req_coord_y;
                  held_in[5] = req_coord_z;
                  hnum_in[1] = req_vertex_number;
                  phase_in   = 2'd2;
               end else begin
                  held_in[0] = req_coord_x;
                  held_in[1] = req_coord_y;
                  held_in[2] = req_coord_z;
                  hnum_in[0] = req_vertex_number;
                  phase_in   = 2'd1;
               end
            end
         end
         ST_SETUP: begin
            // edges and origin offset
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = ext_c(held_ff[3+i]) - ext_c(held_ff[i]);
               e2_in[i] = ext_c(cur_ff[i]) - ext_c(held_ff[i]);
               tv_in[i] = ext_c(org_ff[i]) - ext_c(held_ff[i]);
            end
            step_in = '0;
            acc_in  = '0;
         end
         ST_ISSUE: mul_start = 1'b1;
         ST_MUL:   ;
         ST_ACC: begin
            // accumulate the product, retire the sum when the term closes it
            acc_in = acc_sum;
            if (prog.dst != DST_NONE) acc_in = '0;
            unique case (prog.dst)
               DST_P_X: p_in[0] = acc_sum[PQ_W-1:0];
               DST_P_Y: p_in[1] = acc_sum[PQ_W-1:0];
               DST_P_Z: p_in[2] = acc_sum[PQ_W-1:0];
               DST_Q_X: q_in[0] = acc_sum[PQ_W-1:0];
               DST_Q_Y: q_in[1] = acc_sum[PQ_W-1:0];
               DST_Q_Z: q_in[2] = acc_sum[PQ_W-1:0];
               DST_DET: det_in  = acc_sum;
               DST_UN:  un_in   = acc_sum;
               DST_VN:  vn_in   = acc_sum;
               DST_TN:  tn_in   = acc_sum;
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            chk_in  = CHK_DET;
         end
         ST_CHECK: begin
            unique case (chk_ff)
               CHK_DET: chk_in = CHK_U;
               CHK_U:   chk_in = CHK_V;
               CHK_V:   chk_in = CHK_T;
               default: chk_in = CHK_DET;
            endcase
            dsel_in = DIV_T;
         end
         ST_DIVGO: div_start = 1'b1;
         ST_DIVW: begin
            if (div_done) begin
               unique case (dsel_ff)
                  DIV_T: begin
                     t_in    = div_quo;
                     dsel_in = DIV_U;
                  end
                  DIV_U: begin
                     u_in    = div_quo;
                     dsel_in = DIV_V;
                  end
                  default: begin
                     v_in    = div_quo;
                     dsel_in = DIV_T;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            // replace only on a strictly closer hit
            if (!best_found_ff || (t_ff < best_t_ff)) begin
               best_found_in = 1'b1;
               best_t_in     = t_ff;
               best_u_in     = u_ff;
               best_v_in     = v_ff;
               bvert_in[0]   = hnum_ff[0];
               bvert_in[1]   = hnum_ff[1];
               bvert_in[2]   = cnum_ff;
            end
         end
         ST_FINISH: ;
         ST_EMIT: begin
            // load the result word and start a fresh mesh
            if (emit_go) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = best_found_ff;
               rsp_t_in      = best_t_ff;
               rsp_u_in      = best_u_ff;
               rsp_v_in      = best_v_ff;
               rsp_vert_in   = bvert_ff;
               phase_in      = 2'd0;
               best_found_in = 1'b0;
               best_t_in     = '0;
               best_u_in     = '0;
               best_v_in     = '0;
               bvert_in[0]   = '0;
               bvert_in[1]   = '0;
               bvert_in[2]   = '0;
            end
         end
         default: ;
      endcase
   end

   // control and reset-valued state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 2'd0;
         rsp_valid_ff  <= 1'b0;
         org_ff[0]     <= '0;
         org_ff[1]     <= '0;
         org_ff[2]     <= '0;
         dir_ff[0]     <= '0;
         dir_ff[1]     <= '0;
         dir_ff[2]     <= DIR_Z_RST;
         thr_ff        <= (CW-1)'(1);
         best_found_ff <= 1'b0;
         best_t_ff     <= '0;
         best_u_ff     <= '0;
         best_v_ff     <= '0;
         bvert_ff[0]   <= '0;
         bvert_ff[1]   <= '0;
         bvert_ff[2]   <= '0;
         step_ff       <= '0;
         chk_ff        <= CHK_DET;
         dsel_ff       <= DIV_T;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         org_ff        <= org_in;
         dir_ff        <= dir_in;
         thr_ff        <= thr_in;
         best_found_ff <= best_found_in;
         best_t_ff     <= best_t_in;
         best_u_ff     <= best_u_in;
         best_v_ff     <= best_v_in;
         bvert_ff      <= bvert_in;
         step_ff       <= step_in;
         chk_ff        <= chk_in;
         dsel_ff       <= dsel_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      hnum_ff     <= hnum_in;
      cur_ff      <= cur_in;
      cnum_ff     <= cnum_in;
      clast_ff    <= clast_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      tv_ff       <= tv_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      det_ff      <= det_in;
      un_ff       <= un_in;
      vn_ff       <= vn_in;
      tn_ff       <= tn_in;
      acc_ff      <= acc_in;
      t_ff        <= t_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_t_ff    <= rsp_t_in;
      rsp_u_ff    <= rsp_u_in;
      rsp_v_ff    <= rsp_v_in;
      rsp_vert_ff <= rsp_vert_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_t        = rsp_t_ff;
   assign rsp_hit_u        = rsp_u_ff;
   assign rsp_hit_v        = rsp_v_ff;
   assign rsp_hit_vertex_a = rsp_vert_ff[0];
   assign rsp_hit_vertex_b = rsp_vert_ff[1];
   assign rsp_hit_vertex_c = rsp_vert_ff[2];

   `RMCH_ASSERT_NEXT(a_emit_clears, clock, reset, emit_go, mesh_idle, "mesh not cleared")
   `RMCH_ASSERT_NOW(a_phase_range, clock, reset, 1'b1, phase_ff != 2'd3, "bad vertex phase")
   `RMCH_ASSERT_NOW(a_mul_done, clock, reset, mul_done, state_ff == ST_MUL, "stray mul done")
   `RMCH_ASSERT_NOW(a_div_done, clock, reset, div_done, state_ff == ST_DIVW, "stray div done")

endmodule

>>> tb/sv/tb_ray_mesh_closest_hit_unit.sv
// Self-checking testbench for the closest-hit unit: meshes in, one hit word per mesh out.
`timescale 1ns / 1ps

module tb_ray_mesh_closest_hit_unit;
   import rmch_pkg::*;

   localparam int CW   = COORD_WIDTH_DEF;
   localparam int FB   = FRAC_BITS_DEF;
   localparam int ONE  = 1 << FB;
   localparam int SETTLE_CYCLES = 1500;

   typedef logic signed [159:0] wide_type;

   typedef struct packed {
      logic          hit;
      logic [CW-1:0] t;
      logic [CW-1:0] u;
      logic [CW-1:0] v;
      logic [31:0]   va;
      logic [31:0]   vb;
      logic [31:0]   vc;
   } hit_word_type;

   // Closest-hit predictor plus the queue of hit words still owed by the unit.
   class hit_scoreboard;
      logic [CW-1:0] ray_reg[7];
      logic signed [CW-1:0] held_xyz[6];
      logic [31:0] held_num[2];
      int unsigned phase;
      hit_word_type best;
      hit_word_type owed[$];
      int unsigned errors, checked, hits;

      function new();
         for (int i = 0; i < 7; i++) ray_reg[i] = '0;
         ray_reg[CSR_DIR_Z] = ONE;
         ray_reg[CSR_THRESHOLD] = 1;
         phase = 0;
         best = '0;
         errors = 0;
         checked = 0;
         hits = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CW-1:0] data);
         if (idx == CSR_THRESHOLD) ray_reg[idx] = {1'b0, data[CW-2:0]};
         else ray_reg[idx] = data;
      endfunction

      function logic [CW-1:0] ratio(wide_type n, wide_type den);
         wide_type qq;
         qq = (n <<< FB) / den;
         if (qq > wide_type'(32'h7FFF_FFFF)) return 32'h7FFF_FFFF;
         return qq[CW-1:0];
      endfunction

      // Run the ray test on the triangle closed by this vertex and keep the nearest hit.
      function void close_triangle(logic signed [CW-1:0] c[3], logic [31:0] num);
         wide_type e1[3], e2[3], tv[3], d[3], p[3], q[3];
         wide_type det, un, vn, tn, thr;
         logic [CW-1:0] t, u, v;
         for (int i = 0; i < 3; i++) begin
            e1[i] = wide_type'(held_xyz[3+i]) - wide_type'(held_xyz[i]);
            e2[i] = wide_type'(c[i]) - wide_type'(held_xyz[i]);
            tv[i] = wide_type'($signed(ray_reg[i])) - wide_type'(held_xyz[i]);
            d[i]  = wide_type'($signed(ray_reg[3+i]));
         end
         p[0] = d[1]*e2[2] - d[2]*e2[1];
         p[1] = d[2]*e2[0] - d[0]*e2[2];
         p[2] = d[0]*e2[1] - d[1]*e2[0];
         det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
         thr = wide_type'({1'b0, ray_reg[CSR_THRESHOLD]}) <<< (2*FB);
         if (det <= 0 || det < thr) return;
         un = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
         if (un < 0 || un > det) return;
         q[0] = tv[1]*e1[2] - tv[2]*e1[1];
         q[1] = tv[2]*e1[0] - tv[0]*e1[2];
         q[2] = tv[0]*e1[1] - tv[1]*e1[0];
         vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
         if (vn < 0 || un + vn > det) return;
         tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
         if (tn <= 0) return;
         t = ratio(tn, det);
         u = ratio(un, det);
         v = ratio(vn, det);
         if (!best.hit || t < best.t) begin
            best.hit = 1'b1;
            best.t = t;
            best.u = u;
            best.v = v;
            best.va = held_num[0];
            best.vb = held_num[1];
            best.vc = num;
         end
      endfunction

      // Note one accepted vertex word.
      function void note_vertex(logic signed [CW-1:0] c[3], logic [31:0] num, logic last);
         if (phase < 2) begin
            for (int i = 0; i < 3; i++) held_xyz[phase*3+i] = c[i];
            held_num[phase] = num;
            phase++;
         end else begin
            close_triangle(c, num);
            phase = 0;
         end
         if (last) begin
            owed.push_back(best);
            if (best.hit) hits++;
            best = '0;
            phase = 0;
         end
      endfunction

      // Compare one accepted hit word with the oldest owed one.
      function void check_word(hit_word_type got);
         hit_word_type exp_w;
         checked++;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected hit word: %p", got);
            return;
         end
         exp_w = owed.pop_front();
         if (got !== exp_w) begin
            errors++;
            if (errors <= 10)
               $display({"word %0d: exp hit=%0b t=%h u=%h v=%h a=%h b=%h c=%h,",
                         " got hit=%0b t=%h u=%h v=%h a=%h b=%h c=%h"},
                        checked, exp_w.hit, exp_w.t, exp_w.u, exp_w.v, exp_w.va, exp_w.vb,
                        exp_w.vc, got.hit, got.t, got.u, got.v, got.va, got.vb, got.vc);
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CW-1:0] csr_data;
   logic req_valid, req_ready;
   logic signed [CW-1:0] req_coord_x, req_coord_y, req_coord_z;
   logic [NUM_W-1:0] req_vertex_number;
   logic req_last_vertex;
   logic rsp_valid, rsp_ready, rsp_hit;
   logic signed [CW-1:0] rsp_hit_t, rsp_hit_u, rsp_hit_v;
   logic [NUM_W-1:0] rsp_hit_vertex_a, rsp_hit_vertex_b, rsp_hit_vertex_c;

   hit_scoreboard sb = new();
   bit idling_on = 1'b1;
   int unsigned mesh_count = 0;

   ray_mesh_closest_hit_unit dut (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Hard stop in case the unit hangs.
   initial begin
      #40_000_000;
      $display("ray_mesh_closest_hit_unit: mismatch");
      $finish;
   end

   // Receiver: accept hit words, stall in random bursts.
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_word({rsp_hit, rsp_hit_t, rsp_hit_u, rsp_hit_v,
                           rsp_hit_vertex_a, rsp_hit_vertex_b, rsp_hit_vertex_c});
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Send one vertex word, with an optional idle burst first.
   task automatic send_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z, logic [31:0] num, logic last);
      logic signed [CW-1:0] c[3];
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_vertex_number <= num;
      req_last_vertex <= last;
      do @(posedge clock); while (!req_ready);
      c[0] = x;
      c[1] = y;
      c[2] = z;
      sb.note_vertex(c, num, last);
      if (last) mesh_count++;
   endtask

   // Hold the sender until every owed word is back and the unit has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all seven ray registers; the unit must be idle.
   task automatic load_ray(logic [CW-1:0] vals[7]);
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(csr_index_type'(i), vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [CW-1:0] units(int n);
      return CW'(n * ONE);
   endfunction

   function automatic logic signed [CW-1:0] jitter(int span);
      return CW'($signed($urandom_range(0, 2*span*ONE)) - span*ONE);
   endfunction

   // One mesh of random triangles near the ray, with degenerate and noise triangles mixed in.
   task automatic send_mesh(int ntri, int tail);
      logic signed [CW-1:0] ox, oy, oz, zt;
      logic signed [CW-1:0] ax, ay, az;
      logic [31:0] nb;
      int kind;
      ox = sb.ray_reg[CSR_ORIGIN_X];
      oy = sb.ray_reg[CSR_ORIGIN_Y];
      oz = sb.ray_reg[CSR_ORIGIN_Z];
      nb = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
      for (int k = 0; k < ntri; k++) begin
         kind = $urandom_range(0, 9);
         zt = oz + CW'($urandom_range(0, 20*ONE)) - CW'(ONE);
         if (kind == 0) zt = oz + CW'($urandom_range(1, 3));
         if (kind == 9) begin
            for (int j = 0; j < 3; j++)
               send_vertex($urandom, $urandom, $urandom, $urandom,
                           (k == ntri-1 && tail == 0 && j == 2));
         end else begin
            ax = ox + jitter(4);
            ay = oy + jitter(4);
            az = zt + jitter(1) / 8;
            send_vertex(ax, ay, az, nb, 1'b0);
            send_vertex(ox + jitter(4), oy + jitter(4), zt + jitter(1) / 8, nb + 1, 1'b0);
            // repeat the first corner for a zero-area triangle
            if (kind == 8)
               send_vertex(ax, ay, az, nb + 2, (k == ntri-1 && tail == 0));
            else
               send_vertex(ox + jitter(4), oy + jitter(4), zt + jitter(1) / 8, nb + 2,
                           (k == ntri-1 && tail == 0));
         end
         nb += 3;
      end
      for (int j = 0; j < tail; j++)
         send_vertex(ox + jitter(4), oy + jitter(4), oz + jitter(8), nb + j, (j == tail-1));
   endtask

   initial begin
      logic [CW-1:0] ray[7];
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      req_vertex_number = '0;
      req_last_vertex = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed meshes on the reset ray: hit, equal t, back face, tiny t, partial ends, extreme coordinates.
      send_vertex(-units(1), -units(1), units(2), 32'd0, 1'b0);
      send_vertex(-units(1), units(2), units(2), 32'hFFFF_FFFF, 1'b0);
      send_vertex(units(2), -units(1), units(2), 32'h8000_0001, 1'b1);
      send_vertex(-units(1), -units(1), units(3), 32'd10, 1'b0);
      send_vertex(-units(1), units(2), units(3), 32'd11, 1'b0);
      send_vertex(units(2), -units(1), units(3), 32'd12, 1'b0);
      send_vertex(-units(1), -units(1), units(3), 32'd20, 1'b0);
      send_vertex(-units(1), units(2), units(3), 32'd21, 1'b0);
      send_vertex(units(2), -units(1), units(3), 32'd22, 1'b1);
      send_vertex(-units(1), -units(1), 32'sd1, 32'd30, 1'b0);
      send_vertex(units(2), -units(1), 32'sd1, 32'd31, 1'b0);
      send_vertex(-units(1), units(2), 32'sd1, 32'd32, 1'b1);
      send_vertex(-units(1), -units(1), 32'sd1, 32'd40, 1'b0);
      send_vertex(-units(1), units(2), 32'sd1, 32'd41, 1'b0);
      send_vertex(units(2), -units(1), 32'sd1, 32'd42, 1'b0);
      send_vertex(units(1), units(1), units(1), 32'd43, 1'b0);
      send_vertex(units(1), units(1), units(1), 32'd44, 1'b1);
      send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd50, 1'b1);
      send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'd60, 1'b0);
      send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd61, 1'b0);
      send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'd62, 1'b1);
      drain();

      // Random phases, each on its own ray setting; extremes on phases 1 and 4.
      for (int ph = 0; ph < 6; ph++) begin
         for (int i = 0; i < 3; i++) ray[i] = jitter(50);
         ray[CSR_DIR_X] = jitter(1) / 16;
         ray[CSR_DIR_Y] = jitter(1) / 16;
         ray[CSR_DIR_Z] = CW'($urandom_range(ONE/4, 4*ONE));
         ray[CSR_THRESHOLD] = $urandom_range(0, 3);
         if (ph == 1) begin
            ray[CSR_ORIGIN_X] = 32'h7FFF_FFFF;
            ray[CSR_ORIGIN_Y] = 32'h8000_0000;
            ray[CSR_DIR_X] = 32'h8000_0000;
            ray[CSR_THRESHOLD] = 32'h7FFF_FFFF;
         end else if (ph == 4) begin
            ray[CSR_ORIGIN_Z] = 32'h8000_0000;
            ray[CSR_DIR_Y] = 32'h7FFF_FFFF;
            ray[CSR_DIR_Z] = 32'h7FFF_FFFF;
            ray[CSR_THRESHOLD] = 0;
         end else if (ph == 3) begin
            ray[CSR_DIR_Z] = 32'h0000_0000;
            ray[CSR_DIR_X] = CW'(ONE);
            ray[CSR_THRESHOLD] = 0;
         end
         load_ray(ray);
         if (ph == 5) idling_on = 1'b0;
         for (int m = 0; m < 11; m++) begin
            send_mesh($urandom_range(1, 3),
                      $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
            if (ph == 2 && m == 3) drain();
         end
         drain();
      end

      $display("covered %0d meshes, %0d hit words checked, %0d with a hit", mesh_count,
               sb.checked, sb.hits);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("ray_mesh_closest_hit_unit: match");
      end else begin
         $display("%0d mismatches, %0d words never returned", sb.errors, sb.owed.size());
         $display("ray_mesh_closest_hit_unit: mismatch");
      end
      $finish;
   end

endmodule

>>> ray_mesh_closest_hit_unit.f
+incdir+hw/rtl
hw/rtl/rmch_pkg.sv
hw/rtl/rmch_mul.sv
hw/rtl/rmch_div.sv
hw/rtl/ray_mesh_closest_hit_unit.sv
tb/sv/tb_ray_mesh_closest_hit_unit.sv
